>>> rtl/fcis_pkg.sv
// Shared types and constants for the input-side FIR convolution block.
`default_nettype none

package fcis_pkg;

	localparam int MAX_TAPS_DEF = 16;
	localparam int SAMPLE_W = 16;
	localparam int PROD_W = 32;
	localparam int SUM_W = 40;
	localparam int TAP_COUNT_W = 5;
	localparam int CNT_XW = 7;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [ADDR_W-1:0] ADDR_TAP_COUNT = 3'd0;
	localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 5'd1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef struct packed {
		logic opcode;
		logic [3:0] tap_index;
		logic signed [SAMPLE_W-1:0] value;
		logic last_sample;
	} in_word_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] out_value;
		logic out_last;
	} out_word_t;

	typedef struct packed {
		logic load_we;
		logic capture;
		logic rd_en;
		logic rot_en;
		logic rot_add;
		logic emit;
		logic emit_last;
		logic clear;
	} dp_cmd_t;

	typedef struct packed {
		logic out_ready;
	} dp_sts_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ACC   = 4'b0010,
		ST_EMIT  = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

endpackage

`default_nettype wire

>>> rtl/fcis_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module fcis_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic             re,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/fcis_datapath.sv
// Datapath: tap RAM, multiplier, rotating row of partial sums and output register.
`default_nettype none

module fcis_datapath #(
	parameter int MAX_TAPS = fcis_pkg::MAX_TAPS_DEF,
	parameter int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire fcis_pkg::dp_cmd_t   cmd,
	input  wire logic [AW-1:0]       addr,
	input  wire fcis_pkg::in_word_t  in_word,
	output fcis_pkg::dp_sts_t        sts,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output fcis_pkg::out_word_t      out_word
);
	import fcis_pkg::*;

	logic [SAMPLE_W-1:0] coef;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0] row_q [MAX_TAPS];
	logic signed [SUM_W-1:0] addend;
	logic signed [SUM_W-1:0] head_sum;
	logic out_valid_q;
	out_word_t out_q;

	fcis_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(MAX_TAPS),
		.AW(AW)
	) u_tap_ram (
		.clk(clk),
		.we(cmd.load_we),
		.re(cmd.rd_en),
		.addr(addr),
		.wdata(in_word.value),
		.rdata(coef)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= in_word.value;
		end
		prod_s2 <= sample_q * $signed(coef);
	end

	always_comb begin
		addend = cmd.rot_add ? {{(SUM_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2} : '0;
		head_sum = row_q[0] + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				row_q[i] <= '0;
			end
		end else if (cmd.clear) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				row_q[i] <= '0;
			end
		end else if (cmd.rot_en) begin
			for (int i = 0; i < MAX_TAPS - 1; i++) begin
				row_q[i] <= row_q[i+1];
			end
			row_q[MAX_TAPS-1] <= head_sum;
		end else if (cmd.emit) begin
			for (int i = 0; i < MAX_TAPS - 1; i++) begin
				row_q[i] <= row_q[i+1];
			end
			row_q[MAX_TAPS-1] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.out_value <= row_q[0];
			out_q.out_last <= cmd.emit_last;
		end
	end

	assign sts.out_ready = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_word = out_q;

endmodule

`default_nettype wire

>>> rtl/fcis_ctrl.sv
// Controller: sequences tap reads, row rotation, result emission and tail flush.
`default_nettype none

module fcis_ctrl #(
	parameter int MAX_TAPS = fcis_pkg::MAX_TAPS_DEF,
	parameter int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire fcis_pkg::in_word_t                  in_word,
	input  wire logic [fcis_pkg::TAP_COUNT_W-1:0]    tap_count,
	input  wire fcis_pkg::dp_sts_t                   sts,
	output fcis_pkg::dp_cmd_t                        cmd,
	output logic [AW-1:0]                            addr
);
	import fcis_pkg::*;

	localparam int CW = $clog2(MAX_TAPS + 1);
	localparam int SW = $clog2(MAX_TAPS + 2);
	localparam int XW = (AW > 4) ? AW : 4;

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [SW-1:0] step_q, step_d;
	logic last_q, last_d;
	logic accept;
	logic [CNT_XW-1:0] tc_ext;
	logic [CNT_XW-1:0] idx_ext;
	logic [CW-1:0] active;
	logic [SW-1:0] tap;
	logic [XW-1:0] load_addr;
	logic flush_done;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign tc_ext = CNT_XW'(tap_count);
	assign idx_ext = CNT_XW'(in_word.tap_index);
	assign load_addr = XW'(in_word.tap_index);
	assign tap = step_q - SW'(2);
	assign flush_done = ((step_q + SW'(1)) == SW'(count_q));

	always_comb begin
		if (tc_ext == '0) begin
			active = CW'(1);
		end else if (tc_ext > CNT_XW'(MAX_TAPS)) begin
			active = CW'(MAX_TAPS);
		end else begin
			active = CW'(tap_count);
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		step_d = step_q;
		last_d = last_q;
		cmd = '0;
		addr = load_addr[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_word.opcode == OP_LOAD) begin
					cmd.load_we = (idx_ext < CNT_XW'(MAX_TAPS));
				end
				if (accept && in_word.opcode == OP_SAMPLE) begin
					cmd.capture = 1'b1;
					count_d = active;
					last_d = in_word.last_sample;
					step_d = '0;
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				addr = step_q[AW-1:0];
				cmd.rd_en = (step_q < SW'(MAX_TAPS));
				cmd.rot_en = (step_q >= SW'(2));
				cmd.rot_add = cmd.rot_en && (tap < SW'(count_q));
				step_d = step_q + SW'(1);
				if (step_q == SW'(MAX_TAPS + 1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_ready) begin
					cmd.emit = 1'b1;
					cmd.emit_last = last_q && (count_q == CW'(1));
					cmd.clear = cmd.emit_last;
					step_d = SW'(1);
					if (last_q && count_q != CW'(1)) begin
						state_d = ST_FLUSH;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_FLUSH: begin
				if (sts.out_ready) begin
					cmd.emit = 1'b1;
					cmd.emit_last = flush_done;
					cmd.clear = flush_done;
					step_d = step_q + SW'(1);
					if (flush_done) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= CW'(1);
			step_q <= '0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			step_q <= step_d;
			last_q <= last_d;
		end
	end

	a_emit_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_ready)
		else $error("result emitted while output register is occupied");

	a_sample_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_word.opcode == OP_SAMPLE) |=> (state_q == ST_ACC))
		else $error("accepted sample did not start accumulation");

	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> last_q)
		else $error("tail flush without a final sample");

	a_clear_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> (cmd.emit && cmd.emit_last))
		else $error("row cleared outside the final result");

endmodule

`default_nettype wire

>>> rtl/fir_convolution_input_side_top.sv
// Top level of the input-side FIR convolution block with its register port.
//
// Input words arrive on in_valid/in_stall/in_word. A load word writes one
// Q1.15 coefficient into the tap RAM and leaves the controller idle. A sample
// word is multiplied by every tap while a row of MAX_TAPS partial sums rotates
// once through the adder, one tap per cycle behind a RAM read and a multiplier
// stage; only the active taps add their products. The input stays stalled
// until the controller is idle again. The finished sum then goes to the
// output register. A sample marked last also flushes tail sums, one per
// cycle unless the output stalls, as many as tap_count - 1 with tap_count
// held to 1..MAX_TAPS; the final one carries out_last; the row is then cleared.
// While the receiver holds out_stall the result waits in the output register
// and the next result cannot leave the row, so the block stops there; a new
// input word is still taken whenever the controller is idle.
// Reset clears the partial sums and the output valid flag and sets tap_count to 1.
// Coefficients are not reset and must be loaded before use. Register
// tap_count lies at address 0 of the register port; the user must write it
// only while the block is idle, which the block itself does not enforce.
`default_nettype none

module fir_convolution_input_side_top #(
	parameter int MAX_TAPS = fcis_pkg::MAX_TAPS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire fcis_pkg::in_word_t            in_word,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output fcis_pkg::out_word_t                out_word,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [fcis_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [fcis_pkg::DATA_W-1:0]   pwdata,
	output logic      [fcis_pkg::DATA_W-1:0]   prdata,
	output logic                               pready
);
	import fcis_pkg::*;

	localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

	logic [TAP_COUNT_W-1:0] tap_count_q;
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic [AW-1:0] addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_COUNT_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_TAP_COUNT) begin
			tap_count_q <= pwdata[TAP_COUNT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_TAP_COUNT) ? DATA_W'(tap_count_q) : '0;

	fcis_ctrl #(
		.MAX_TAPS(MAX_TAPS),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.tap_count(tap_count_q),
		.sts(sts),
		.cmd(cmd),
		.addr(addr)
	);

	fcis_datapath #(
		.MAX_TAPS(MAX_TAPS),
		.AW(AW)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.addr(addr),
		.in_word(in_word),
		.sts(sts),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word)
	);

endmodule

`default_nettype wire
